// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Depends on nothing; every use names its clock and reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dvt_pkg.sv -----
// Package for the delta-V charge termination block: word types, slot record,
// configuration register map and fixed thresholds. Depends on nothing.
package dvt_pkg;

    localparam int NUM_SLOTS_DEF = 2;
    localparam int SAMPLE_BITS   = 12;
    localparam int CNT_BITS      = 8;
    localparam int SECS_BITS     = 16;
    localparam int FLAG_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CNT_BITS-1:0] RISE_ADOPT   = CNT_BITS'(10);
    localparam logic [CNT_BITS-1:0] FULL_CONFIRM = CNT_BITS'(20);
    localparam logic [CNT_BITS-1:0] LEAK_STEP    = CNT_BITS'(5);
    localparam logic [CNT_BITS-1:0] CNT_MAX      = CNT_BITS'(255);

    localparam int FLAG_FULL = 0;
    localparam int FLAG_MDV  = 1;
    localparam int FLAG_ZDV  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DV_START_SECONDS      = 3'd0,
        CFG_DV_START_VOLTAGE      = 3'd1,
        CFG_DELTA_V_DROP          = 3'd2,
        CFG_DV_CONFIRM_COUNT      = 3'd3,
        CFG_ZERO_DV_CONFIRM_COUNT = 3'd4,
        CFG_FULL_VOLTAGE          = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SECS_BITS-1:0]   dv_start_seconds;
        logic [SAMPLE_BITS-1:0] dv_start_voltage;
        logic [CNT_BITS-1:0]    delta_v_drop;
        logic [CNT_BITS-1:0]    dv_confirm_count;
        logic [CNT_BITS-1:0]    zero_dv_confirm_count;
        logic [SAMPLE_BITS-1:0] full_voltage;
    } t_cfg;

    typedef struct packed {
        logic                   battery_index;
        logic [SAMPLE_BITS-1:0] voltage;
        logic [SECS_BITS-1:0]   elapsed_seconds;
        logic                   over_temperature;
        logic                   timer_expired;
        logic                   clear_slot;
    } t_in_word;

    typedef struct packed {
        logic slot_out;
        logic full_flag;
        logic minus_dv_flag;
        logic zero_dv_flag;
        logic terminate;
    } t_out_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak_voltage;
        logic [CNT_BITS-1:0]    rise_count;
        logic [CNT_BITS-1:0]    drop_count;
        logic [CNT_BITS-1:0]    flat_count;
        logic [CNT_BITS-1:0]    full_count;
        logic [FLAG_BITS-1:0]   latched_flags;
    } t_slot_rec;

    localparam int REC_BITS = $bits(t_slot_rec);

endpackage

// ----- rtl/dvt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/dvt_update.sv -----
// Per-slot update: clear, or delta-V, zero-delta-V and full-voltage checks on one record.
// Depends on dvt_pkg.
module dvt_update (
    input  dvt_pkg::t_cfg      i_cfg,
    input  dvt_pkg::t_in_word  i_word,
    input  logic               i_in_range,
    input  dvt_pkg::t_slot_rec i_rec,
    output dvt_pkg::t_slot_rec o_rec,
    output dvt_pkg::t_out_word o_result
);

    function automatic logic [dvt_pkg::CNT_BITS-1:0] count_up(
        input logic [dvt_pkg::CNT_BITS-1:0] c
    );
        return (c >= dvt_pkg::CNT_MAX) ? dvt_pkg::CNT_MAX : c + 1'b1;
    endfunction

    function automatic logic [dvt_pkg::CNT_BITS-1:0] leak(
        input logic [dvt_pkg::CNT_BITS-1:0] c
    );
        return (c > dvt_pkg::LEAK_STEP) ? c - dvt_pkg::LEAK_STEP : '0;
    endfunction

    dvt_pkg::t_slot_rec                 rec;
    logic                               enabled;
    logic                               dv_run;
    logic [dvt_pkg::SAMPLE_BITS-1:0]    drop_amt;
    logic [dvt_pkg::FLAG_BITS-1:0]      flags;

    always_comb begin
        rec      = i_rec;
        enabled  = (i_word.elapsed_seconds > i_cfg.dv_start_seconds)
                || (i_word.voltage > i_cfg.dv_start_voltage);
        dv_run   = enabled && (i_rec.latched_flags == '0)
                && !i_word.over_temperature && !i_word.timer_expired;
        drop_amt = i_rec.peak_voltage - i_word.voltage;

        if (i_word.clear_slot) begin
            rec = '0;
        end else begin
            if (dv_run) begin
                if (i_rec.peak_voltage < i_word.voltage) begin
                    rec.rise_count = count_up(i_rec.rise_count);
                    if (rec.rise_count >= dvt_pkg::RISE_ADOPT) begin
                        rec.peak_voltage = i_word.voltage;
                        rec.drop_count   = '0;
                        rec.flat_count   = '0;
                    end
                end else begin
                    rec.rise_count = leak(i_rec.rise_count);
                    rec.flat_count = count_up(i_rec.flat_count);
                    if (rec.flat_count >= i_cfg.zero_dv_confirm_count) begin
                        rec.latched_flags[dvt_pkg::FLAG_ZDV] = 1'b1;
                    end
                    if (drop_amt >= dvt_pkg::SAMPLE_BITS'(i_cfg.delta_v_drop)) begin
                        rec.drop_count = count_up(i_rec.drop_count);
                        if (rec.drop_count >= i_cfg.dv_confirm_count) begin
                            rec.latched_flags[dvt_pkg::FLAG_MDV] = 1'b1;
                        end
                    end else begin
                        rec.drop_count = leak(i_rec.drop_count);
                    end
                end
            end
            if (!rec.latched_flags[dvt_pkg::FLAG_FULL]) begin
                if (i_word.voltage >= i_cfg.full_voltage) begin
                    rec.full_count = count_up(i_rec.full_count);
                end else begin
                    rec.full_count = leak(i_rec.full_count);
                end
                if (rec.full_count >= dvt_pkg::FULL_CONFIRM) begin
                    rec.latched_flags[dvt_pkg::FLAG_FULL] = 1'b1;
                end
            end
        end

        flags = i_in_range ? rec.latched_flags : '0;

        o_rec                  = rec;
        o_result.slot_out      = i_word.battery_index;
        o_result.full_flag     = flags[dvt_pkg::FLAG_FULL];
        o_result.minus_dv_flag = flags[dvt_pkg::FLAG_MDV];
        o_result.zero_dv_flag  = flags[dvt_pkg::FLAG_ZDV];
        o_result.terminate     = (flags != '0) || i_word.over_temperature
                              || i_word.timer_expired;
    end

endmodule

// ----- rtl/delta_v_charge_termination.sv -----
// NiMH charge termination (minus-delta-V, zero-delta-V, full voltage), one
// voltage word per battery slot. It takes one word per clock unless stalled.
// The slot record is read from a memory with registered read data; as the word
// leaves stage one, the record is updated and written back and the result is
// registered. A bypass register covers back-to-back words for the same slot.
// Per-slot valid bits make a slot read as cleared after reset, so there is no
// clearing pass. Depends on dvt_pkg, dvt_ram, dvt_update, assert_macros.svh.
`include "assert_macros.svh"

module delta_v_charge_termination #(
    parameter int NUM_SLOTS = dvt_pkg::NUM_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  dvt_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output dvt_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dvt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dvt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    dvt_pkg::t_cfg       r_cfg;
    logic [NUM_SLOTS-1:0] r_slot_vld;

    logic                r_s1_valid;
    dvt_pkg::t_in_word   r_s1_word;
    logic                r_s1_in_range;
    logic                r_rd_vld;
    logic                r_byp_hit;
    dvt_pkg::t_slot_rec  r_byp_data;

    logic                r_out_valid;
    dvt_pkg::t_out_word  r_out_word;

    logic                in_accept;
    logic                out_free;
    logic                adv1;
    logic                in_range;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [dvt_pkg::REC_BITS-1:0] ram_q;
    dvt_pkg::t_slot_rec  cur_rec;
    dvt_pkg::t_slot_rec  new_rec;
    dvt_pkg::t_out_word  result;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign adv1        = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign in_range = NUM_SLOTS > int'(i_in_word.battery_index);
    assign rd_addr  = AW'(i_in_word.battery_index);
    assign wr_addr  = AW'(r_s1_word.battery_index);
    assign wr_en    = adv1 && r_s1_in_range;

    dvt_ram #(
        .WIDTH (dvt_pkg::REC_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (new_rec),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        if (r_byp_hit) begin
            cur_rec = r_byp_data;
        end else if (r_rd_vld) begin
            cur_rec = dvt_pkg::t_slot_rec'(ram_q);
        end else begin
            cur_rec = '0;
        end
    end

    dvt_update u_update (
        .i_cfg      (r_cfg),
        .i_word     (r_s1_word),
        .i_in_range (r_s1_in_range),
        .i_rec      (cur_rec),
        .o_rec      (new_rec),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dv_start_seconds      <= dvt_pkg::SECS_BITS'(600);
            r_cfg.dv_start_voltage      <= dvt_pkg::SAMPLE_BITS'(2200);
            r_cfg.delta_v_drop          <= dvt_pkg::CNT_BITS'(8);
            r_cfg.dv_confirm_count      <= dvt_pkg::CNT_BITS'(20);
            r_cfg.zero_dv_confirm_count <= dvt_pkg::CNT_BITS'(100);
            r_cfg.full_voltage          <= dvt_pkg::SAMPLE_BITS'(2500);
            r_slot_vld                  <= '0;
            r_s1_valid                  <= 1'b0;
            r_out_valid                 <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    dvt_pkg::CFG_DV_START_SECONDS: begin
                        r_cfg.dv_start_seconds <= i_cfg_data[dvt_pkg::SECS_BITS-1:0];
                    end
                    dvt_pkg::CFG_DV_START_VOLTAGE: begin
                        r_cfg.dv_start_voltage <= i_cfg_data[dvt_pkg::SAMPLE_BITS-1:0];
                    end
                    dvt_pkg::CFG_DELTA_V_DROP: begin
                        r_cfg.delta_v_drop <= i_cfg_data[dvt_pkg::CNT_BITS-1:0];
                    end
                    dvt_pkg::CFG_DV_CONFIRM_COUNT: begin
                        r_cfg.dv_confirm_count <= i_cfg_data[dvt_pkg::CNT_BITS-1:0];
                    end
                    dvt_pkg::CFG_ZERO_DV_CONFIRM_COUNT: begin
                        r_cfg.zero_dv_confirm_count <= i_cfg_data[dvt_pkg::CNT_BITS-1:0];
                    end
                    dvt_pkg::CFG_FULL_VOLTAGE: begin
                        r_cfg.full_voltage <= i_cfg_data[dvt_pkg::SAMPLE_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (wr_en) begin
                r_slot_vld[wr_addr] <= 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv1) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold stage-one payload while stalled; capture bypass on same-slot overlap.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_word     <= i_in_word;
            r_s1_in_range <= in_range;
            r_rd_vld      <= in_range && r_slot_vld[rd_addr];
            r_byp_hit     <= wr_en && in_range && (wr_addr == rd_addr);
            r_byp_data    <= new_rec;
        end
        if (adv1) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        r_s1_valid && r_out_valid, "input stalled while a stage is free")
    `ASSERT_IMPLY(a_bypass_needs_item, i_clk, i_rst_n, r_s1_valid && r_byp_hit,
        r_s1_in_range, "bypass hit without a slot word in stage one")
    `ASSERT_NEXT(a_clear_gives_no_flags, i_clk, i_rst_n, adv1 && r_s1_word.clear_slot,
        o_out_valid && !o_out_word.full_flag && !o_out_word.minus_dv_flag
        && !o_out_word.zero_dv_flag, "cleared slot reports a latched flag")
    `ASSERT_ALWAYS(a_flags_terminate, i_clk, i_rst_n,
        !o_out_valid || o_out_word.terminate
        || !(o_out_word.full_flag || o_out_word.minus_dv_flag || o_out_word.zero_dv_flag),
        "latched flag without terminate")

endmodule
